// ----- src/cimh_pkg.sv -----
// Package for the case-insensitive MurmurHash64A unit: constants, the controller
// state type, command and status structures, and the byte case-folding function.
// Depends on nothing; every other file of the block refers to it by scoped names.
package cimh_pkg;

    // Hash arithmetic constants.
    localparam logic [63:0] MUL_CONST = 64'hc6a4a7935bd1e995;
    localparam int unsigned SHIFT_AMT = 47;

    // Default for the longest name the unit will honour.
    localparam int unsigned MAX_NAME_LEN_DEF = 255;

    // Field widths of one transfer.
    localparam int unsigned WORD_W = 64;
    localparam int unsigned LEN_W  = 8;

    // Operand chosen for the shared multiplier.
    typedef enum logic [2:0] {
        OP_LEN,
        OP_WORD,
        OP_KMIX,
        OP_HXK,
        OP_TAIL,
        OP_FMIX
    } mul_sel_t;

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_BODY,
        ST_KMUL,
        ST_KMIX,
        ST_HMUL,
        ST_TAIL,
        ST_FMIX,
        ST_OUT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     load;
        logic     mul_start;
        mul_sel_t mul_sel;
        logic     wr_k;
        logic     wr_h;
        logic     bytes_sub8;
        logic     bytes_clear;
        logic     out_load;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic mul_busy;
        logic mul_done;
        logic bytes_zero;
        logic bytes_ge8;
        logic bytes_eq8;
        logic out_free;
    } status_t;

    // Fold ASCII 'A'..'Z' to lower case in each of the eight bytes.
    function automatic logic [63:0] fold_lower(input logic [63:0] w);
        logic [63:0] r;
        logic [7:0]  b;
        r = '0;
        for (int i = 0; i < 8; i++)
        begin
            b = w[8*i +: 8];
            if (b >= 8'h41 && b <= 8'h5A)
            begin
                b = b + 8'h20;
            end
            r[8*i +: 8] = b;
        end
        return r;
    endfunction

endpackage

// ----- src/cimh_mul.sv -----
// Shared 64-bit by constant multiplier, low 64 bits of the product only.
// Depends on cimh_pkg for the multiplier constant; one 32x32 product per cycle.
module cimh_mul (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] operand,
    output logic        busy,
    output logic        done,
    output logic [63:0] product
);

    // Partial product order: low by low, low by high, high by low.
    localparam logic [1:0] STEP_LL = 2'd0;
    localparam logic [1:0] STEP_LH = 2'd1;
    localparam logic [1:0] STEP_HL = 2'd2;

    localparam logic [31:0] M_LO = cimh_pkg::MUL_CONST[31:0];
    localparam logic [31:0] M_HI = cimh_pkg::MUL_CONST[63:32];

    logic [63:0] a_reg;
    logic [63:0] acc_reg;
    logic [63:0] acc_next;
    logic [1:0]  step_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [31:0] a_half;
    logic [31:0] m_half;
    logic [63:0] part;

    // Pick the halves for this step and form one partial product.
    always_comb
    begin
        a_half = (step_reg == STEP_HL) ? a_reg[63:32] : a_reg[31:0];
        m_half = (step_reg == STEP_LH) ? M_HI : M_LO;
        part   = {32'b0, a_half} * {32'b0, m_half};
        if (step_reg == STEP_LL)
        begin
            acc_next = part;
        end
        else
        begin
            acc_next = acc_reg + {part[31:0], 32'b0};
        end
    end

    // Operand and accumulator need no reset.
    always_ff @(posedge clk)
    begin
        if (start && !busy_reg)
        begin
            a_reg <= operand;
        end
        if (busy_reg)
        begin
            acc_reg <= acc_next;
        end
    end

    // Step sequencing.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_LL;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (busy_reg)
            begin
                if (step_reg == STEP_HL)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                    step_reg <= STEP_LL;
                end
                else
                begin
                    step_reg <= step_reg + 2'd1;
                end
            end
            else if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_LL;
            end
        end
    end

    assign busy    = busy_reg;
    assign done    = done_reg;
    assign product = acc_reg;

endmodule

// ----- src/cimh_datapath.sv -----
// Datapath of the hash unit: word, key, hash and length registers, operand
// selection, the output register and the shared multiplier. Depends on cimh_pkg.
module cimh_datapath #(
    parameter int unsigned MAX_NAME_LEN = cimh_pkg::MAX_NAME_LEN_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  cimh_pkg::cmd_t       cmd,
    output cimh_pkg::status_t    status,
    input  logic [63:0]          in_word,
    input  logic [7:0]           in_length,
    input  logic                 in_first,
    input  logic                 out_ready,
    output logic                 out_valid,
    output logic [63:0]          out_hash
);

    logic [63:0] word_reg;
    logic [63:0] k_reg;
    logic [63:0] h_reg;
    logic [7:0]  bytes_left_reg;
    logic [63:0] hash_out_reg;
    logic        out_valid_reg;

    logic [7:0]  len_clamped;
    logic [63:0] tail_mask;
    logic [63:0] mul_operand;
    logic        mul_busy;
    logic        mul_done;
    logic [63:0] mul_product;

    // Clamp the length to the longest name allowed.
    always_comb
    begin
        if (32'(in_length) > MAX_NAME_LEN)
        begin
            len_clamped = 8'(MAX_NAME_LEN);
        end
        else
        begin
            len_clamped = in_length;
        end
    end

    // Keep only the bytes of a partial final word that belong to the name.
    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            tail_mask[8*i +: 8] = (3'(i) < bytes_left_reg[2:0]) ? 8'hFF : 8'h00;
        end
    end

    // Multiplier operand selection.
    always_comb
    begin
        case (cmd.mul_sel)
            cimh_pkg::OP_LEN:  mul_operand = {56'b0, bytes_left_reg};
            cimh_pkg::OP_WORD: mul_operand = word_reg;
            cimh_pkg::OP_KMIX: mul_operand = k_reg ^ (k_reg >> cimh_pkg::SHIFT_AMT);
            cimh_pkg::OP_HXK:  mul_operand = h_reg ^ k_reg;
            cimh_pkg::OP_TAIL: mul_operand = h_reg ^ (word_reg & tail_mask);
            cimh_pkg::OP_FMIX: mul_operand = h_reg ^ (h_reg >> cimh_pkg::SHIFT_AMT);
            default:           mul_operand = word_reg;
        endcase
    end

    cimh_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.mul_start),
        .operand (mul_operand),
        .busy    (mul_busy),
        .done    (mul_done),
        .product (mul_product)
    );

    // Payload registers: folded word, key, hash and the result.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            word_reg <= cimh_pkg::fold_lower(in_word);
        end
        if (cmd.wr_k)
        begin
            k_reg <= mul_product;
        end
        if (cmd.wr_h)
        begin
            h_reg <= mul_product;
        end
        if (cmd.out_load)
        begin
            hash_out_reg <= h_reg ^ (h_reg >> cimh_pkg::SHIFT_AMT);
        end
    end

    // Name bytes still to come, and the output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_left_reg <= 8'd0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.load && in_first)
            begin
                bytes_left_reg <= len_clamped;
            end
            else if (cmd.bytes_sub8)
            begin
                bytes_left_reg <= bytes_left_reg - 8'd8;
            end
            else if (cmd.bytes_clear)
            begin
                bytes_left_reg <= 8'd0;
            end

            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Status for the controller.
    always_comb
    begin
        status.mul_busy   = mul_busy;
        status.mul_done   = mul_done;
        status.bytes_zero = (bytes_left_reg == 8'd0);
        status.bytes_ge8  = (bytes_left_reg >= 8'd8);
        status.bytes_eq8  = (bytes_left_reg == 8'd8);
        status.out_free   = !out_valid_reg || out_ready;
    end

    assign out_valid = out_valid_reg;
    assign out_hash  = hash_out_reg;

endmodule

// ----- src/cimh_ctrl.sv -----
// Controller of the hash unit: sequences the multiplications of each word,
// the tail and the final mix. Depends on cimh_pkg for its state and command types.
module cimh_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_first,
    output logic                 in_ready,
    input  cimh_pkg::status_t    status,
    output cimh_pkg::cmd_t       cmd
);

    cimh_pkg::state_t state_reg;
    cimh_pkg::state_t state_next;
    logic             mul_issue;

    // Start the multiplier once on entering a multiply state.
    assign mul_issue = !status.mul_busy && !status.mul_done;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cimh_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next      = state_reg;
        in_ready        = 1'b0;
        cmd             = '0;
        cmd.mul_sel     = cimh_pkg::OP_LEN;
        case (state_reg)
            cimh_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (in_first)
                    begin
                        state_next = cimh_pkg::ST_INIT;
                    end
                    else if (!status.bytes_zero)
                    begin
                        state_next = cimh_pkg::ST_BODY;
                    end
                end
            end
            cimh_pkg::ST_INIT:
            begin
                cmd.mul_sel   = cimh_pkg::OP_LEN;
                cmd.mul_start = mul_issue;
                if (status.mul_done)
                begin
                    cmd.wr_h   = 1'b1;
                    state_next = status.bytes_zero ? cimh_pkg::ST_FMIX : cimh_pkg::ST_BODY;
                end
            end
            cimh_pkg::ST_BODY:
            begin
                state_next = status.bytes_ge8 ? cimh_pkg::ST_KMUL : cimh_pkg::ST_TAIL;
            end
            cimh_pkg::ST_KMUL:
            begin
                cmd.mul_sel   = cimh_pkg::OP_WORD;
                cmd.mul_start = mul_issue;
                if (status.mul_done)
                begin
                    cmd.wr_k   = 1'b1;
                    state_next = cimh_pkg::ST_KMIX;
                end
            end
            cimh_pkg::ST_KMIX:
            begin
                cmd.mul_sel   = cimh_pkg::OP_KMIX;
                cmd.mul_start = mul_issue;
                if (status.mul_done)
                begin
                    cmd.wr_k   = 1'b1;
                    state_next = cimh_pkg::ST_HMUL;
                end
            end
            cimh_pkg::ST_HMUL:
            begin
                cmd.mul_sel   = cimh_pkg::OP_HXK;
                cmd.mul_start = mul_issue;
                if (status.mul_done)
                begin
                    cmd.wr_h       = 1'b1;
                    cmd.bytes_sub8 = 1'b1;
                    state_next     = status.bytes_eq8 ? cimh_pkg::ST_FMIX : cimh_pkg::ST_IDLE;
                end
            end
            cimh_pkg::ST_TAIL:
            begin
                cmd.mul_sel   = cimh_pkg::OP_TAIL;
                cmd.mul_start = mul_issue;
                if (status.mul_done)
                begin
                    cmd.wr_h        = 1'b1;
                    cmd.bytes_clear = 1'b1;
                    state_next      = cimh_pkg::ST_FMIX;
                end
            end
            cimh_pkg::ST_FMIX:
            begin
                cmd.mul_sel   = cimh_pkg::OP_FMIX;
                cmd.mul_start = mul_issue;
                if (status.mul_done)
                begin
                    cmd.wr_h   = 1'b1;
                    state_next = cimh_pkg::ST_OUT;
                end
            end
            cimh_pkg::ST_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = cimh_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cimh_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ----- src/case_insensitive_murmur64a_hash_unit.sv -----
// Top level of the case-insensitive MurmurHash64A unit (seed 0).
// Depends on cimh_pkg, cimh_ctrl and cimh_datapath (which holds cimh_mul).
//
// Usage: a name is sent on the slave stream as little-endian 8-byte words; the
// transfer that starts a name has tuser set and carries the total length in
// bytes. Lengths above MAX_NAME_LEN are clamped. The master stream gives one
// 64-bit hash after the transfer that completes a name; an empty name gives one
// hash straight away. A word without tuser while no name is open is dropped.
// Every 64-bit multiplication goes through one shared 32x32 multiplier in three
// steps. A full word runs the key product, the key mix and the hash product; a
// partial final word runs the tail product; the opening word of a name first runs
// the length product, and the final mix and the output load follow the last word.
// Only one word is in work at a time.
// The result sits in an output register, so the next name is taken while the
// hash waits; the unit stalls only when a new hash is due and the old one has
// not been taken. Reset clears the controller, the length count and the output
// valid flag; no hash is pending after reset.
module case_insensitive_murmur64a_hash_unit #(
    parameter int unsigned MAX_NAME_LEN = cimh_pkg::MAX_NAME_LEN_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // name_word [63:0], name_length [71:64]
    input  logic        s_axis_tuser,   // first_word [0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata    // hash_value [63:0]
);

    cimh_pkg::cmd_t    cmd;
    cimh_pkg::status_t status;

    // Controller.
    cimh_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_first (s_axis_tuser),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath.
    cimh_datapath #(
        .MAX_NAME_LEN (MAX_NAME_LEN)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_word   (s_axis_tdata[63:0]),
        .in_length (s_axis_tdata[71:64]),
        .in_first  (s_axis_tuser),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_hash  (m_axis_tdata)
    );

endmodule
